FILE: rtl/wia_pkg.sv
// Shared types and constants for the 128-bit integer unit.
package wia_pkg;

  localparam int WORD_BITS  = 128;
  localparam int HALF_BITS  = WORD_BITS / 2;
  localparam int LIMB_BITS  = 32;
  localparam int SHIFT_BITS = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [HALF_BITS-1:0] half_t;

  typedef enum logic [2:0] {
    OP_EXTEND = 3'd0,
    OP_NEGATE = 3'd1,
    OP_ADD    = 3'd2,
    OP_SUB    = 3'd3,
    OP_MUL    = 3'd4,
    OP_SHL    = 3'd5,
    OP_SHR    = 3'd6,
    OP_SAR    = 3'd7
  } op_t;

  typedef struct packed {
    logic pp_en;
    logic sum_en;
  } mul_en_t;

endpackage

FILE: rtl/wia_in_if.sv
// Operation channel: opcode, two operands in halves and a shift amount.
interface wia_in_if;
  import wia_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [2:0]            opcode;
  half_t                 a_low;
  half_t                 a_high;
  half_t                 b_low;
  half_t                 b_high;
  logic [SHIFT_BITS-1:0] shift_amount;

  modport source (output valid, opcode, a_low, a_high, b_low, b_high, shift_amount,
                  input ready);
  modport sink (input valid, opcode, a_low, a_high, b_low, b_high, shift_amount,
                output ready);
endinterface

FILE: rtl/wia_out_if.sv
// Result channel: one 128-bit result in halves.
interface wia_out_if;
  import wia_pkg::*;

  logic  valid;
  logic  ready;
  half_t result_low;
  half_t result_high;

  modport source (output valid, result_low, result_high, input ready);
  modport sink (input valid, result_low, result_high, output ready);
endinterface

FILE: rtl/wia_simple.sv
// Extend, negate, add, subtract and shift datapath.
module wia_simple import wia_pkg::*; (
  input  op_t                   op,
  input  word_t                 a,
  input  word_t                 b,
  input  logic [SHIFT_BITS-1:0] sh,
  output word_t                 result
);

  always_comb begin
    unique case (op)
      OP_EXTEND: result = {{HALF_BITS{a[HALF_BITS-1]}}, a[HALF_BITS-1:0]};
      OP_NEGATE: result = word_t'(0) - a;
      OP_ADD:    result = a + b;
      OP_SUB:    result = a - b;
      OP_MUL:    result = '0;
      OP_SHL:    result = a << sh;
      OP_SHR:    result = a >> sh;
      OP_SAR:    result = word_t'($signed(a) >>> sh);
      default:   result = '0;
    endcase
  end

endmodule

FILE: rtl/wia_mul.sv
// Two-stage 128x128 multiplier that keeps the low 128 bits of the product.
module wia_mul import wia_pkg::*; (
  input  logic    clk,
  input  mul_en_t en,
  input  word_t   a,
  input  word_t   b,
  output word_t   product
);

  localparam int PP_BITS = 2 * LIMB_BITS;

  logic [LIMB_BITS-1:0] a0, a1, a2, a3, b0, b1, b2, b3;
  logic [PP_BITS-1:0]   p00, p01, p02, p10, p11, p20;
  logic [LIMB_BITS-1:0] p03, p12, p21, p30;
  logic [PP_BITS-1:0]   c0;
  logic [PP_BITS:0]     c1;
  logic [PP_BITS+1:0]   c2;
  logic [LIMB_BITS-1:0] c3;

  assign {a3, a2, a1, a0} = a;
  assign {b3, b2, b1, b0} = b;

  always_ff @(posedge clk) begin
    if (en.pp_en) begin
      p00 <= PP_BITS'(a0) * PP_BITS'(b0);
      p01 <= PP_BITS'(a0) * PP_BITS'(b1);
      p02 <= PP_BITS'(a0) * PP_BITS'(b2);
      p03 <= a0 * b3;
      p10 <= PP_BITS'(a1) * PP_BITS'(b0);
      p11 <= PP_BITS'(a1) * PP_BITS'(b1);
      p12 <= a1 * b2;
      p20 <= PP_BITS'(a2) * PP_BITS'(b0);
      p21 <= a2 * b1;
      p30 <= a3 * b0;
    end
  end

  // Partial products are summed per limb weight; the top weight only needs its low limb.
  always_ff @(posedge clk) begin
    if (en.sum_en) begin
      c0 <= p00;
      c1 <= {1'b0, p01} + {1'b0, p10};
      c2 <= {2'b00, p02} + {2'b00, p11} + {2'b00, p20};
      c3 <= p03 + p12 + p21 + p30;
    end
  end

  assign product = word_t'(c0)
                 + (word_t'(c1) << LIMB_BITS)
                 + (word_t'(c2) << (2 * LIMB_BITS))
                 + (word_t'(c3) << (3 * LIMB_BITS));

endmodule

FILE: rtl/wide_integer_alu_128.sv
// Top level of the 128-bit integer unit: four-stage pipeline with output register.
//
// The unit accepts one operation per cycle unless the result side stalls, and
// returns its 128-bit results in order. Every operation goes through the same four
// stages: an operand register, a stage of 32x32 partial products (where extend,
// negate, add, subtract and shifts also finish), a stage of per-weight partial
// product sums, and the result register after the final multiplier add. Each stage
// holds its contents only while the stage after it is full and stalled, so a stall
// on the result side fills the pipeline before the input stops taking transfers.
module wide_integer_alu_128 import wia_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  wia_in_if.sink    in_ch,
  wia_out_if.source out_ch
);

  logic                  valid_a, valid_b, valid_c, valid_d;
  logic                  en_a, en_b, en_c, en_d;
  op_t                   op_a;
  word_t                 opa_a, opb_a;
  logic [SHIFT_BITS-1:0] sh_a;
  logic                  is_mul_b, is_mul_c;
  word_t                 simple_b, simple_c, simple_next;
  word_t                 product;
  word_t                 result;
  mul_en_t               mul_en;

  assign en_d = !valid_d || out_ch.ready;
  assign en_c = !valid_c || en_d;
  assign en_b = !valid_b || en_c;
  assign en_a = !valid_a || en_b;
  assign in_ch.ready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
      valid_d <= 1'b0;
    end else begin
      if (en_a) valid_a <= in_ch.valid;
      if (en_b) valid_b <= valid_a;
      if (en_c) valid_c <= valid_b;
      if (en_d) valid_d <= valid_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      op_a  <= op_t'(in_ch.opcode);
      opa_a <= {in_ch.a_high, in_ch.a_low};
      opb_a <= {in_ch.b_high, in_ch.b_low};
      sh_a  <= in_ch.shift_amount;
    end
    if (en_b) begin
      is_mul_b <= (op_a == OP_MUL);
      simple_b <= simple_next;
    end
    if (en_c) begin
      is_mul_c <= is_mul_b;
      simple_c <= simple_b;
    end
    if (en_d) begin
      result <= is_mul_c ? product : simple_c;
    end
  end

  wia_simple u_simple (
    .op     (op_a),
    .a      (opa_a),
    .b      (opb_a),
    .sh     (sh_a),
    .result (simple_next)
  );

  assign mul_en.pp_en  = en_b;
  assign mul_en.sum_en = en_c;

  wia_mul u_mul (
    .clk     (clk),
    .en      (mul_en),
    .a       (opa_a),
    .b       (opb_a),
    .product (product)
  );

  assign out_ch.valid       = valid_d;
  assign out_ch.result_low  = result[HALF_BITS-1:0];
  assign out_ch.result_high = result[WORD_BITS-1:HALF_BITS];

endmodule
